FILE: sv/host_command_frame_encoder_macros.svh
// assertion macros used by the checker file of the frame encoder
`ifndef HOST_COMMAND_FRAME_ENCODER_MACROS_SVH
`define HOST_COMMAND_FRAME_ENCODER_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define HCFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define HCFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/hcfe_pkg.sv
// package of the host command frame encoder: beat types, frame constants, phases
`timescale 1ns / 1ps

package hcfe_pkg;

    localparam logic [7:0] DIR_WRITE = 8'h01;
    localparam logic [7:0] PREAMBLE  = 8'h00;
    localparam logic [7:0] START_LO  = 8'h00;
    localparam logic [7:0] START_HI  = 8'hFF;
    localparam logic [7:0] TFI_HOST  = 8'hD4;
    localparam logic [7:0] POSTAMBLE = 8'h00;

    // header byte slots
    localparam logic [2:0] HDR_DIR   = 3'd0;
    localparam logic [2:0] HDR_PRE   = 3'd1;
    localparam logic [2:0] HDR_SLO   = 3'd2;
    localparam logic [2:0] HDR_SHI   = 3'd3;
    localparam logic [2:0] HDR_LEN   = 3'd4;
    localparam logic [2:0] HDR_LCS   = 3'd5;
    localparam logic [2:0] HDR_TFI   = 3'd6;

    // number of beats on the line before the first payload byte
    localparam int unsigned HDR_BEATS = 7;

    typedef struct packed {
        logic [7:0] cmd_byte;
        logic [7:0] cmd_len;
    } cmd_beat_t;

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       frame_last;
    } wire_beat_t;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_BODY,
        PH_DCS,
        PH_POST
    } phase_t;

    function automatic logic [7:0] hdr_byte(input logic [2:0] idx, input logic [7:0] len);
        logic [7:0] lenf;
        logic [7:0] res;
        lenf = 8'(len + 8'd1);
        unique case (idx)
            HDR_DIR: res = DIR_WRITE;
            HDR_PRE: res = PREAMBLE;
            HDR_SLO: res = START_LO;
            HDR_SHI: res = START_HI;
            HDR_LEN: res = lenf;
            HDR_LCS: res = 8'(8'd0 - lenf);
            HDR_TFI: res = TFI_HOST;
            default: res = PREAMBLE;
        endcase
        return res;
    endfunction

endpackage

FILE: sv/host_command_frame_encoder.sv
// top level of the host command frame encoder
`timescale 1ns / 1ps

// Frames a stream of command bytes into host-to-chip normal information frames.
// The first byte of a frame carries the payload length in cmd_len; it produces
// seven header beats (direction, preamble, start code, LEN, LCS, TFI) and then
// the byte itself. Middle bytes produce one beat each, and the byte that ends
// the payload produces itself, DCS and the postamble, which has frame_last set.
// A length of zero emits the header, DCS and postamble and drops the byte.
// One output beat leaves per cycle while frame_ready is not held low: body
// bytes flow at one byte per cycle unless the output stalls, while a first
// byte holds the input until its header beats have gone, and a closing byte
// until its DCS and postamble have gone; all beats of a byte go through the
// single output register. An accepted byte is registered in the holding
// register, and each of its beats then in the output register.
module host_command_frame_encoder (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  hcfe_pkg::cmd_beat_t    cmd_data,
    output logic                   frame_valid,
    input  logic                   frame_ready,
    output hcfe_pkg::wire_beat_t   frame_data
);

    localparam logic [2:0] HdrLast = 3'(hcfe_pkg::HDR_BEATS - 1);

    // holding register for the byte being framed
    logic                 hold_valid_reg, hold_valid_next;
    hcfe_pkg::cmd_beat_t  hold_beat_reg, hold_beat_next;
    hcfe_pkg::phase_t     phase_reg, phase_next;
    logic [2:0]           hdr_idx_reg, hdr_idx_next;

    // frame state
    logic                 in_frame_reg, in_frame_next;
    logic [7:0]           bytes_left_reg, bytes_left_next;
    logic [7:0]           data_sum_reg, data_sum_next;

    // output register
    logic                 out_valid_reg;
    hcfe_pkg::wire_beat_t out_beat_reg;

    hcfe_pkg::wire_beat_t emit_beat;
    logic                 item_done;
    logic                 advance;
    logic                 cmd_accept;

    assign advance    = hold_valid_reg && (!out_valid_reg || frame_ready);
    assign cmd_ready  = !hold_valid_reg || (advance && item_done);
    assign cmd_accept = cmd_valid && cmd_ready;

    assign frame_valid = out_valid_reg;
    assign frame_data  = out_beat_reg;

    // beat to emit and whether it is the last one for the held byte
    always_comb
    begin
        emit_beat = '{wire_byte: hcfe_pkg::PREAMBLE, frame_last: 1'b0};
        item_done = 1'b0;
        unique case (phase_reg)
            hcfe_pkg::PH_HDR:
            begin
                emit_beat.wire_byte = hcfe_pkg::hdr_byte(hdr_idx_reg, hold_beat_reg.cmd_len);
            end
            hcfe_pkg::PH_BODY:
            begin
                emit_beat.wire_byte = hold_beat_reg.cmd_byte;
                item_done           = (bytes_left_reg != 8'd1);
            end
            hcfe_pkg::PH_DCS:
            begin
                emit_beat.wire_byte = 8'(8'd0 - data_sum_reg);
            end
            hcfe_pkg::PH_POST:
            begin
                emit_beat.wire_byte  = hcfe_pkg::POSTAMBLE;
                emit_beat.frame_last = 1'b1;
                item_done            = 1'b1;
            end
            default:
            begin
                item_done = 1'b1;
            end
        endcase
    end

    // next state
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_beat_next  = hold_beat_reg;
        phase_next      = phase_reg;
        hdr_idx_next    = hdr_idx_reg;
        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        data_sum_next   = data_sum_reg;

        if (advance)
        begin
            unique case (phase_reg)
                hcfe_pkg::PH_HDR:
                begin
                    hdr_idx_next = 3'(hdr_idx_reg + 3'd1);
                    if (hdr_idx_reg == HdrLast)
                    begin
                        data_sum_next = hcfe_pkg::TFI_HOST;
                        if (hold_beat_reg.cmd_len == 8'd0)
                        begin
                            phase_next = hcfe_pkg::PH_DCS;
                        end
                        else
                        begin
                            in_frame_next   = 1'b1;
                            bytes_left_next = hold_beat_reg.cmd_len;
                            phase_next      = hcfe_pkg::PH_BODY;
                        end
                    end
                end
                hcfe_pkg::PH_BODY:
                begin
                    data_sum_next   = 8'(data_sum_reg + hold_beat_reg.cmd_byte);
                    bytes_left_next = 8'(bytes_left_reg - 8'd1);
                    if (bytes_left_reg == 8'd1)
                    begin
                        phase_next = hcfe_pkg::PH_DCS;
                    end
                end
                hcfe_pkg::PH_DCS:
                begin
                    phase_next = hcfe_pkg::PH_POST;
                end
                hcfe_pkg::PH_POST:
                begin
                    in_frame_next   = 1'b0;
                    bytes_left_next = 8'd0;
                end
                default:
                begin
                    phase_next = hcfe_pkg::PH_HDR;
                end
            endcase
            if (item_done)
            begin
                hold_valid_next = 1'b0;
            end
        end

        // a new byte starts on the header unless its frame is already open
        if (cmd_accept)
        begin
            hold_valid_next = 1'b1;
            hold_beat_next  = cmd_data;
            hdr_idx_next    = hcfe_pkg::HDR_DIR;
            phase_next      = in_frame_next ? hcfe_pkg::PH_BODY : hcfe_pkg::PH_HDR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= hcfe_pkg::PH_HDR;
            hdr_idx_reg    <= hcfe_pkg::HDR_DIR;
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 8'd0;
            data_sum_reg   <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
            hdr_idx_reg    <= hdr_idx_next;
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
            data_sum_reg   <= data_sum_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frame_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_beat_reg <= hold_beat_next;
        if (advance)
        begin
            out_beat_reg <= emit_beat;
        end
    end

endmodule

FILE: sv/hcfe_checker.sv
// port-level checker for the host command frame encoder, with its bind
`timescale 1ns / 1ps
`include "host_command_frame_encoder_macros.svh"

module hcfe_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  logic                 cmd_ready,
    input  hcfe_pkg::cmd_beat_t  cmd_data,
    input  logic                 frame_valid,
    input  logic                 frame_ready,
    input  hcfe_pkg::wire_beat_t frame_data
);

    logic       out_acc;
    logic [8:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] lcs_sum;

    assign out_acc = frame_valid && frame_ready;
    assign lcs_sum = 8'(frame_data.wire_byte + len_reg);

    // position of the beat within its frame on the line
    always_comb
    begin
        pos_next = pos_reg;
        len_next = len_reg;
        if (out_acc)
        begin
            pos_next = frame_data.frame_last ? 9'd0 : 9'(pos_reg + 9'd1);
            if (pos_reg == 9'(hcfe_pkg::HDR_LEN))
            begin
                len_next = frame_data.wire_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 9'd0;
            len_reg <= 8'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
        end
    end

    `HCFE_ASSERT_NEXT(a_in_hold, clk, rst_n, cmd_valid && !cmd_ready,
        cmd_valid && $stable(cmd_data), "input beat changed while stalled")

    `HCFE_ASSERT_NEXT(a_out_hold, clk, rst_n, frame_valid && !frame_ready,
        frame_valid && $stable(frame_data), "output beat changed while stalled")

    `HCFE_ASSERT_NOW(a_dir_first, clk, rst_n, out_acc && pos_reg == 9'd0,
        frame_data.wire_byte == hcfe_pkg::DIR_WRITE, "frame does not open with direction byte")

    `HCFE_ASSERT_NOW(a_lcs, clk, rst_n, out_acc && pos_reg == 9'(hcfe_pkg::HDR_LCS),
        lcs_sum == 8'd0, "length checksum does not cancel length")

    // a frame ends no earlier than an empty frame, whose postamble follows the header and dcs
    `HCFE_ASSERT_NOW(a_last_late, clk, rst_n, out_acc && frame_data.frame_last,
        pos_reg >= 9'(hcfe_pkg::HDR_BEATS + 1), "frame ended before header and trailer")

endmodule

bind host_command_frame_encoder hcfe_checker u_hcfe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd_data    (cmd_data),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame_data  (frame_data)
);
